// ===== design/sws_pkg.sv =====
package sws_pkg;

   localparam int DEPTH      = 16;
   localparam int AW         = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 5;
   localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int DATA_W     = 32;
   localparam int CMD_W      = 3;
   localparam int STAT_W     = 2;
   localparam int OCC_W      = 5;
   localparam int RSP_DATA_W = 40;
   localparam int CAP_RESET  = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_SEARCH = 3'd2,
      CMD_REV    = 3'd3,
      CMD_DEDUP  = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2,
      STAT_EMPTY_OP  = 2'd3
   } status_type;

endpackage

// ===== design/sws_ram.sv =====
module sws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== design/stack_with_search_reverse_dedup_core.sv =====
// Channel  Direction  Handshake                 Payload
// req      in         req_tvalid / req_tready   tuser: command; tdata: operand_value
// rsp      out        rsp_tvalid / rsp_tready   tdata: read_value..is_full; tuser: status
// csr      in         csr_we                    csr_wdata: capacity
//
// Push, unknown commands, and pop, search, reverse and dedup on an empty stack go
// straight to the result state, as does reverse on a single entry; the other
// commands walk the entries, and every word walks through the single read port of
// the entry RAM. Entries are undefined until pushed, no clearing pass.
// A request is taken whenever the sequencer is idle, even while a result waits;
// a finished result holds in the sequencer until the output register is free.
module stack_with_search_reverse_dedup_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sws_pkg::DATA_W-1:0]        req_tdata,  // operand_value
   input  logic [sws_pkg::CMD_W-1:0]         req_tuser,  // command
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_value[31:0], found[32], occupancy[37:33], is_empty[38], is_full[39]
   output logic [sws_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [sws_pkg::STAT_W-1:0]        rsp_tuser,  // status
   input  logic                              csr_we,
   input  logic [sws_pkg::CAP_W-1:0]         csr_wdata   // capacity
);
   import sws_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE    = 12'b0000_0000_0001,
      S_POP     = 12'b0000_0000_0010,
      S_SRCH    = 12'b0000_0000_0100,
      S_REV_LO  = 12'b0000_0000_1000,
      S_REV_HI  = 12'b0000_0001_0000,
      S_REV_WL  = 12'b0000_0010_0000,
      S_REV_WH  = 12'b0000_0100_0000,
      S_DD_RD   = 12'b0000_1000_0000,
      S_DD_CAP  = 12'b0001_0000_0000,
      S_DD_SCAN = 12'b0010_0000_0000,
      S_DD_WR   = 12'b0100_0000_0000,
      S_FIN     = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] rv_ff, rv_in;
   logic found_ff, found_in;
   status_type status_ff, status_in;
   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0] idx_ff, idx_in, rd_ff, rd_in, wr_ff, wr_in;
   logic pend_ff, pend_in, dup_ff, dup_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0] rsp_user_ff, rsp_user_in;

   logic ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   logic req_fire;
   logic [CMP_W-1:0] eff_cap;
   logic at_cap;
   logic match;

   sws_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // capacity saturates at the RAM depth
   assign eff_cap = (CMP_W'(cap_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_ff);
   assign at_cap  = (CMP_W'(count_ff) >= eff_cap);
   assign match   = pend_ff && (ram_rdata == val_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cap_in       = csr_we ? csr_wdata : cap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      val_in       = val_ff;
      rv_in        = rv_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      pend_in      = pend_ff;
      dup_in       = dup_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = req_tdata;
      ram_raddr    = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rv_in     = '0;
               found_in  = 1'b0;
               status_in = STAT_OK;
               val_in    = req_tdata;
               pend_in   = 1'b0;
               state_in  = S_FIN;
               case (cmd_type'(req_tuser))
                  CMD_PUSH: begin
                     if (at_cap) begin
                        status_in = STAT_OVERFLOW;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        rv_in     = '1;
                        status_in = STAT_UNDERFLOW;
                     end else begin
                        count_in  = CNT_W'(count_ff - 1'b1);
                        ram_raddr = count_in[AW-1:0];
                        state_in  = S_POP;
                     end
                  end
                  CMD_SEARCH: begin
                     idx_in = '0;
                     if (count_ff != '0) begin
                        state_in = S_SRCH;
                     end
                  end
                  CMD_REV: begin
                     lo_in = '0;
                     hi_in = AW'(count_ff - 1'b1);
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY_OP;
                     end else if (count_ff != CNT_W'(1)) begin
                        state_in = S_REV_LO;
                     end
                  end
                  CMD_DEDUP: begin
                     rd_in = '0;
                     wr_in = '0;
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY_OP;
                     end else begin
                        state_in = S_DD_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            rv_in    = ram_rdata;
            state_in = S_FIN;
         end
         S_SRCH: begin
            if (match) begin
               found_in = 1'b1;
            end
            if (idx_ff < count_ff) begin
               ram_raddr = idx_ff[AW-1:0];
               idx_in    = CNT_W'(idx_ff + 1'b1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_FIN;
               end
            end
         end
         S_REV_LO: begin
            ram_raddr = lo_ff;
            state_in  = S_REV_HI;
         end
         S_REV_HI: begin
            ram_raddr = hi_ff;
            val_in    = ram_rdata;
            state_in  = S_REV_WL;
         end
         S_REV_WL: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff;
            ram_wdata = ram_rdata;
            state_in  = S_REV_WH;
         end
         S_REV_WH: begin
            ram_we    = 1'b1;
            ram_waddr = hi_ff;
            ram_wdata = val_ff;
            lo_in     = AW'(lo_ff + 1'b1);
            hi_in     = AW'(hi_ff - 1'b1);
            state_in  = (lo_in < hi_in) ? S_REV_LO : S_FIN;
         end
         S_DD_RD: begin
            ram_raddr = rd_ff[AW-1:0];
            state_in  = S_DD_CAP;
         end
         S_DD_CAP: begin
            val_in   = ram_rdata;
            idx_in   = CNT_W'(rd_ff + 1'b1);
            pend_in  = 1'b0;
            dup_in   = 1'b0;
            state_in = S_DD_SCAN;
         end
         S_DD_SCAN: begin
            // a copy nearer the top makes this entry a duplicate
            if (match) begin
               dup_in = 1'b1;
            end
            if (idx_ff < count_ff) begin
               ram_raddr = idx_ff[AW-1:0];
               idx_in    = CNT_W'(idx_ff + 1'b1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_DD_WR;
               end
            end
         end
         S_DD_WR: begin
            // compact kept entries downward; writes stay at or below the read point
            if (!dup_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_ff[AW-1:0];
               ram_wdata = val_ff;
               wr_in     = CNT_W'(wr_ff + 1'b1);
            end
            rd_in = CNT_W'(rd_ff + 1'b1);
            if (rd_in < count_ff) begin
               state_in = S_DD_RD;
            end else begin
               count_in = wr_in;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // hold the result until the output register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {at_cap, (count_ff == '0), OCC_W'(count_ff), found_ff, rv_ff};
               rsp_user_in  = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_W'(CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      rv_ff       <= rv_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      idx_ff      <= idx_in;
      rd_ff       <= rd_in;
      wr_ff       <= wr_in;
      pend_ff     <= pend_in;
      dup_ff      <= dup_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy beyond RAM depth");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("sequencer idle right after a request");

   a_search_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> !ram_we)
      else $error("entry write during search");

   a_dedup_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DD_WR) |-> wr_ff <= rd_ff)
      else $error("dedup write pointer passed read pointer");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_valid_ff && !rsp_tready) |=> state_ff == S_FIN)
      else $error("result dropped while output stalled");

endmodule

// ===== tb/sv/stack_with_search_reverse_dedup_core_test.sv =====
`timescale 1ns / 100ps

module stack_with_search_reverse_dedup_core_test;
   import sws_pkg::*;

   localparam logic [CMD_W-1:0] FIRST_UNKNOWN_CMD = 3'd5;
   localparam logic [CMD_W-1:0] LAST_UNKNOWN_CMD  = 3'd7;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_REQUESTS  = 200;
   localparam int SETTLE_CYCLES   = 250;
   localparam int HOLD_CYCLES     = 400;
   localparam int POOL_SIZE       = 6;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [DATA_W-1:0] operand;
   } stack_request_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              found;
      status_type        status;
      logic [OCC_W-1:0]  occupancy;
      logic              is_empty;
      logic              is_full;
   } stack_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;   // operand_value
   logic [CMD_W-1:0]      req_tuser = '0;   // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // read_value[31:0], found[32], occupancy[37:33], is_empty[38], is_full[39]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;        // status
   logic                  csr_we = 1'b0;
   logic [CAP_W-1:0]      csr_wdata = '0;

   stack_with_search_reverse_dedup_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the stack, updated as each request is taken
   logic [DATA_W-1:0] shadow_words[DEPTH];
   int                shadow_count = 0;
   int                shadow_cap = CAP_RESET;

   stack_request_type pending_requests[$];
   stack_result_type  expected_results[$];
   stack_request_type offered;
   int             requests_queued = 0;
   int             responses_seen = 0;
   int             failures = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   bit             backpressure_on = 1'b0;
   int             backpressure_cycles = 0;
   int             cmd_counts[8];
   int             status_counts[4];
   int             capacity_writes = 0;
   logic [DATA_W-1:0] value_pool[POOL_SIZE];
   int unsigned    phase_caps[RANDOM_PHASES] = '{16, 1, 0, 31, 5, 16, 2, 9};

   function automatic stack_result_type stack_apply(logic [CMD_W-1:0] command,
                                                    logic [DATA_W-1:0] operand);
      stack_result_type  r;
      int                eff;
      int                lo;
      int                hi;
      bit                dup;
      logic [DATA_W-1:0] t;
      logic [DATA_W-1:0] kept[$];
      r = '0;
      r.status = STAT_OK;
      eff = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
      case (command)
         CMD_PUSH: begin
            if (shadow_count >= eff) begin
               r.status = STAT_OVERFLOW;
            end else begin
               shadow_words[shadow_count] = operand;
               shadow_count++;
            end
         end
         CMD_POP: begin
            if (shadow_count == 0) begin
               r.read_value = '1;
               r.status = STAT_UNDERFLOW;
            end else begin
               shadow_count--;
               r.read_value = shadow_words[shadow_count];
            end
         end
         CMD_SEARCH: begin
            for (int i = 0; i < shadow_count; i++)
               if (shadow_words[i] == operand) r.found = 1'b1;
         end
         CMD_REV: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY_OP;
            end else begin
               lo = 0;
               hi = shadow_count - 1;
               while (lo < hi) begin
                  t = shadow_words[lo];
                  shadow_words[lo] = shadow_words[hi];
                  shadow_words[hi] = t;
                  lo++;
                  hi--;
               end
            end
         end
         CMD_DEDUP: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY_OP;
            end else begin
               // walk down from the top, keep the first sighting of each value
               for (int i = shadow_count - 1; i >= 0; i--) begin
                  dup = 1'b0;
                  foreach (kept[j])
                     if (kept[j] == shadow_words[i]) dup = 1'b1;
                  if (!dup) kept.push_back(shadow_words[i]);
               end
               shadow_count = kept.size();
               for (int i = 0; i < shadow_count; i++)
                  shadow_words[i] = kept[shadow_count - 1 - i];
            end
         end
         default: ;
      endcase
      r.occupancy = shadow_count[OCC_W-1:0];
      r.is_empty  = (shadow_count == 0);
      r.is_full   = (shadow_count >= eff);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(stack_apply(offered.command, offered.operand));
            cmd_counts[offered.command]++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= offered.command;
               req_tdata  <= offered.operand;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      stack_result_type want;
      stack_result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            got.read_value = rsp_tdata[31:0];
            got.found      = rsp_tdata[32];
            got.status     = status_type'(rsp_tuser);
            got.occupancy  = rsp_tdata[37:33];
            got.is_empty   = rsp_tdata[38];
            got.is_full    = rsp_tdata[39];
            status_counts[rsp_tuser]++;
            if (expected_results.size() == 0) begin
               $error("result with no request outstanding: tdata %h tuser %0d",
                      rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (got.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         $signed(want.read_value), $signed(got.read_value));
                  failures++;
               end
               if (got.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, got.found);
                  failures++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %s, got %s", want.status.name(),
                         got.status.name());
                  failures++;
               end
               if (got.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy,
                         got.occupancy);
                  failures++;
               end
               if (got.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                  failures++;
               end
               if (got.is_full !== want.is_full) begin
                  $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
                  failures++;
               end
            end
         end
         // hold off for a long stretch so the core fills up and drops req_tready
         if (backpressure_on && backpressure_cycles < HOLD_CYCLES) begin
            backpressure_cycles++;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic queue_request(logic [CMD_W-1:0] command, logic [DATA_W-1:0] operand);
      stack_request_type item;
      item.command = command;
      item.operand = operand;
      pending_requests.push_back(item);
      requests_queued++;
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      shadow_cap = cap;
      capacity_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (responses_seen < requests_queued) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random_requests(int count);
      int                roll;
      bit                filling;
      logic [CMD_W-1:0]  command;
      logic [DATA_W-1:0] operand;
      for (int n = 0; n < count; n++) begin
         // alternate push-heavy and pop-heavy runs to reach full and empty
         filling = ((n / 40) % 2) == 0;
         roll = $urandom_range(99);
         if (roll < (filling ? 55 : 20))      command = CMD_PUSH;
         else if (roll < (filling ? 70 : 65)) command = CMD_POP;
         else if (roll < (filling ? 82 : 77)) command = CMD_SEARCH;
         else if (roll < (filling ? 89 : 85)) command = CMD_REV;
         else if (roll < 96)                  command = CMD_DEDUP;
         else command = CMD_W'($urandom_range(FIRST_UNKNOWN_CMD, LAST_UNKNOWN_CMD));
         if ($urandom_range(99) < 60)
            operand = value_pool[$urandom_range(POOL_SIZE - 1)];
         else
            operand = $urandom;
         queue_request(command, operand);
      end
   endtask

   function automatic logic [CMD_W-1:0] CMD_UNKNOWN_MID();
      return FIRST_UNKNOWN_CMD + 3'd1;
   endfunction

   initial begin
      int mode;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part at a small capacity
      write_capacity(5'd3);
      queue_request(CMD_POP, 32'h0);
      queue_request(CMD_REV, 32'h0);
      queue_request(CMD_DEDUP, 32'h0);
      queue_request(CMD_SEARCH, 32'h0);
      queue_request(CMD_PUSH, 32'h8000_0000);
      queue_request(CMD_PUSH, 32'h7FFF_FFFF);
      queue_request(CMD_PUSH, 32'h0);
      queue_request(CMD_PUSH, 32'hFFFF_FFFF);
      queue_request(CMD_SEARCH, 32'h7FFF_FFFF);
      queue_request(CMD_SEARCH, 32'hFFFF_FFFF);
      queue_request(CMD_REV, 32'h0);
      queue_request(CMD_DEDUP, 32'h0);
      queue_request(FIRST_UNKNOWN_CMD, 32'h1234_5678);
      queue_request(CMD_UNKNOWN_MID(), 32'hFFFF_FFFF);
      queue_request(LAST_UNKNOWN_CMD, 32'h0);
      queue_request(CMD_POP, 32'h0);
      queue_request(CMD_POP, 32'h0);
      queue_request(CMD_POP, 32'h0);
      queue_request(CMD_POP, 32'h0);
      queue_request(CMD_PUSH, 32'd7);
      queue_request(CMD_PUSH, 32'd9);
      queue_request(CMD_PUSH, 32'd7);
      queue_request(CMD_DEDUP, 32'h0);
      queue_request(CMD_POP, 32'h0);
      queue_request(CMD_SEARCH, 32'd7);
      wait_for_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode = phase % 4;
         send_idle_pct  = (mode == 1) ? 50 : (mode == 3) ? 16 : 0;
         recv_stall_pct = (mode == 2) ? 50 : (mode == 3) ? 16 : 0;
         write_capacity(phase_caps[phase][CAP_W-1:0]);
         foreach (value_pool[i]) value_pool[i] = $urandom;
         value_pool[0] = (phase % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         if (phase == 0) backpressure_on = 1'b1;
         queue_random_requests(PHASE_REQUESTS);
         wait_for_results();
      end

      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         failures++;
      end
      $display("Ran %0d requests under %0d capacity settings: %0d push, %0d pop, %0d search,",
               requests_queued, capacity_writes, cmd_counts[CMD_PUSH], cmd_counts[CMD_POP],
               cmd_counts[CMD_SEARCH]);
      $display("  %0d reverse, %0d dedup; %0d overflow, %0d underflow, %0d empty-stack errors",
               cmd_counts[CMD_REV], cmd_counts[CMD_DEDUP], status_counts[STAT_OVERFLOW],
               status_counts[STAT_UNDERFLOW], status_counts[STAT_EMPTY_OP]);
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #16_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sws_pkg.sv
design/sws_ram.sv
design/stack_with_search_reverse_dedup_core.sv
tb/sv/stack_with_search_reverse_dedup_core_test.sv
